// ----- rtl/tks_pkg.sv -----
// Shared constants, types and the entry ordering function of the top-K selector.
// Depends on nothing; every other file of the block but tks_ram imports it.
package tks_pkg;

    localparam int K_MAX      = 64;
    localparam int INDEX_BITS = 20;
    localparam int SCORE_BITS = 32;
    localparam int K_SEL_W    = 7;
    localparam int RANK_W     = 6;
    localparam int ADDR_W     = $clog2(K_MAX);
    localparam int CNT_W      = $clog2(K_MAX + 1);

    localparam logic [K_SEL_W-1:0] K_SELECT_RESET = K_SEL_W'(16);

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic [INDEX_BITS-1:0]        idx;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                  load;
        logic [INDEX_BITS-1:0] idx;
        logic [RANK_W-1:0]     rank;
        logic                  last;
    } out_load_t;

    // True when entry a ranks below entry b: lower score, or equal score and larger index.
    function automatic logic entry_worse(input entry_t a, input entry_t b);
        logic lt;
        logic eq;
        lt = $signed(a.score) < $signed(b.score);
        eq = a.score == b.score;
        return lt || (eq && (a.idx > b.idx));
    endfunction

endpackage

// ----- rtl/tks_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module tks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ----- rtl/tks_out_stage.sv -----
// Output register of the selector: holds one result until the receiver takes it.
// Depends on tks_pkg.
module tks_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tks_pkg::out_load_t              load_in,
    output logic                            free,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tks_pkg::INDEX_BITS-1:0]  point_index_res,
    output logic [tks_pkg::RANK_W-1:0]      rank,
    output logic                            last_result
);
    import tks_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic                  last_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        if (load_in.load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in.load)
        begin
            idx_reg  <= load_in.idx;
            rank_reg <= load_in.rank;
            last_reg <= load_in.last;
        end
    end

    assign out_valid       = valid_reg;
    assign point_index_res = idx_reg;
    assign rank            = rank_reg;
    assign last_result     = last_reg;

endmodule

// ----- rtl/tks_heap_ctrl.sv -----
// Heap sequencer: insert with sift-up, replace-minimum with sift-down, in-place
// heapsort at the end of a batch and readout. Depends on tks_pkg; drives tks_ram.
module tks_heap_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tks_pkg::INDEX_BITS-1:0] point_index,
    input  logic signed [tks_pkg::SCORE_BITS-1:0] score,
    input  logic                           last_item,
    input  logic                           cfg_we,
    input  logic [tks_pkg::K_SEL_W-1:0]    cfg_wdata,
    output logic                           ram_we,
    output logic [tks_pkg::ADDR_W-1:0]     ram_waddr,
    output tks_pkg::entry_t                ram_wdata,
    output logic                           ram_re,
    output logic [tks_pkg::ADDR_W-1:0]     ram_raddr,
    input  tks_pkg::entry_t                ram_rdata,
    input  logic                           out_free,
    output tks_pkg::out_load_t             out_load
);
    import tks_pkg::*;

    localparam int CMP_W = ADDR_W + 2;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_UP_RD  = 13'b0000000000010,
        S_UP_CMP = 13'b0000000000100,
        S_RP_CMP = 13'b0000000001000,
        S_DN_L   = 13'b0000000010000,
        S_DN_R   = 13'b0000000100000,
        S_DN_SEL = 13'b0000001000000,
        S_FIN    = 13'b0000010000000,
        S_SRT0   = 13'b0000100000000,
        S_SRT1   = 13'b0001000000000,
        S_SRT2   = 13'b0010000000000,
        S_EM_RD  = 13'b0100000000000,
        S_EM_LD  = 13'b1000000000000
    } state_t;

    function automatic logic [CNT_W-1:0] k_eff(input logic [K_SEL_W-1:0] k);
        if (k == '0)
        begin
            return CNT_W'(1);
        end
        else if (int'(k) > K_MAX)
        begin
            return CNT_W'(K_MAX);
        end
        return CNT_W'(k);
    endfunction

    state_t             state_reg, state_next;
    entry_t             new_reg, new_next;
    entry_t             cand_reg, cand_next;
    logic               last_reg, last_next;
    logic               sorting_reg, sorting_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   hsize_reg, hsize_next;
    logic [CNT_W-1:0]   emit_n_reg, emit_n_next;
    logic [ADDR_W-1:0]  p_reg, p_next;
    logic [ADDR_W-1:0]  cidx_reg, cidx_next;
    logic [ADDR_W-1:0]  ecnt_reg, ecnt_next;
    logic [K_SEL_W-1:0] k_sel_reg;

    logic [CNT_W-1:0]   keff;
    logic [ADDR_W-1:0]  parent;
    logic [ADDR_W-1:0]  last_slot;
    logic [CMP_W-1:0]   left_c;
    logic [CMP_W-1:0]   right_c;
    logic [CMP_W-1:0]   hsize_c;
    logic               has_left;
    logic               has_right;
    entry_t             child;
    logic [ADDR_W-1:0]  child_addr;

    assign keff      = k_eff(k_sel_reg);
    assign parent    = (p_reg - 1'b1) >> 1;
    assign last_slot = ADDR_W'(hsize_reg - 1'b1);
    assign left_c    = {1'b0, p_reg, 1'b1};
    assign right_c   = left_c + 1'b1;
    assign hsize_c   = CMP_W'(hsize_reg);
    assign has_left  = left_c < hsize_c;
    assign has_right = right_c < hsize_c;

    // Worse of the two children; with only a left child it is the word just read.
    always_comb
    begin
        child      = ram_rdata;
        child_addr = left_c[ADDR_W-1:0];
        if (state_reg == S_DN_SEL)
        begin
            if (entry_worse(ram_rdata, cand_reg))
            begin
                child      = ram_rdata;
                child_addr = right_c[ADDR_W-1:0];
            end
            else
            begin
                child      = cand_reg;
                child_addr = cidx_reg;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        new_next     = new_reg;
        cand_next    = cand_reg;
        last_next    = last_reg;
        sorting_next = sorting_reg;
        count_next   = count_reg;
        hsize_next   = hsize_reg;
        emit_n_next  = emit_n_reg;
        p_next       = p_reg;
        cidx_next    = cidx_reg;
        ecnt_next    = ecnt_reg;
        in_ready     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = p_reg;
        ram_wdata    = new_reg;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        out_load     = '0;

        unique case (state_reg) inside
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    new_next.score = score;
                    new_next.idx   = point_index;
                    last_next      = last_item;
                    if (count_reg < keff)
                    begin
                        p_next     = count_reg[ADDR_W-1:0];
                        count_next = count_reg + 1'b1;
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_RP_CMP;
                    end
                end
            end
            S_UP_RD:
            begin
                if (p_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (entry_worse(new_reg, ram_rdata))
                begin
                    ram_wdata  = ram_rdata;
                    p_next     = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RP_CMP:
            begin
                // Only a strictly higher score displaces the current minimum.
                if ($signed(new_reg.score) > $signed(ram_rdata.score))
                begin
                    p_next       = '0;
                    hsize_next   = count_reg;
                    sorting_next = 1'b0;
                    state_next   = S_DN_L;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_L:
            begin
                if (has_left)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = left_c[ADDR_W-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = sorting_reg ? S_SRT0 : S_FIN;
                end
            end
            S_DN_R, S_DN_SEL:
            begin
                if ((state_reg == S_DN_R) && has_right)
                begin
                    cand_next  = ram_rdata;
                    cidx_next  = left_c[ADDR_W-1:0];
                    ram_re     = 1'b1;
                    ram_raddr  = right_c[ADDR_W-1:0];
                    state_next = S_DN_SEL;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (entry_worse(child, new_reg))
                    begin
                        ram_wdata  = child;
                        p_next     = child_addr;
                        state_next = S_DN_L;
                    end
                    else
                    begin
                        state_next = sorting_reg ? S_SRT0 : S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (last_reg)
                begin
                    hsize_next   = count_reg;
                    emit_n_next  = (count_reg < keff) ? count_reg : keff;
                    sorting_next = 1'b1;
                    state_next   = S_SRT0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SRT0:
            begin
                if (hsize_reg > CNT_W'(1))
                begin
                    ram_re     = 1'b1;
                    state_next = S_SRT1;
                end
                else
                begin
                    ecnt_next  = '0;
                    state_next = S_EM_RD;
                end
            end
            S_SRT1:
            begin
                cand_next  = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = last_slot;
                state_next = S_SRT2;
            end
            S_SRT2:
            begin
                // The minimum moves to the freed tail slot; the tail entry sifts down.
                new_next   = ram_rdata;
                ram_we     = 1'b1;
                ram_waddr  = last_slot;
                ram_wdata  = cand_reg;
                hsize_next = hsize_reg - 1'b1;
                p_next     = '0;
                state_next = S_DN_L;
            end
            S_EM_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ecnt_reg;
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                if (out_free)
                begin
                    out_load.load = 1'b1;
                    out_load.idx  = ram_rdata.idx;
                    out_load.rank = RANK_W'(ecnt_reg);
                    out_load.last = CNT_W'(ecnt_reg) == (emit_n_reg - 1'b1);
                    if (out_load.last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ecnt_next  = ecnt_reg + 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            k_sel_reg   <= K_SELECT_RESET;
            sorting_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sorting_reg <= sorting_next;
            if (cfg_we)
            begin
                k_sel_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg    <= new_next;
        cand_reg   <= cand_next;
        last_reg   <= last_next;
        hsize_reg  <= hsize_next;
        emit_n_reg <= emit_n_next;
        p_reg      <= p_next;
        cidx_reg   <= cidx_next;
        ecnt_reg   <= ecnt_next;
    end

endmodule

// ----- rtl/top_k_select_min_heap.sv -----
// Top level of the streaming top-K selector built around a min-heap in one RAM.
// Depends on tks_pkg, tks_ram, tks_heap_ctrl and tks_out_stage.
//
// Usage: requests of (point_index, score, last_item) arrive on a valid/ready
// channel. The block keeps the k_select best entries (highest signed Q16.16
// score, smaller index on a tie) in a binary min-heap whose root is the worst
// kept entry. While the heap has room a request is inserted and sifted up;
// once full, a request with a strictly higher score than the root replaces it
// and is sifted down. Each heap level is a registered RAM read followed by a
// compare and a write-back; going down, both children are read in turn. After
// the request flagged last_item, the heap is heapsorted in place (n - 1 pops:
// the root moves to the freed tail slot and the tail entry sifts down) and then
// min(n, k_select) results go out best first with rank and last_result, each
// read from the RAM, then loaded into the output register. No new request is
// taken until the batch is out; the heap then starts empty. When the receiver
// stalls, the result waits in the output register and the readout pauses; a
// new batch may start while the final result still waits. Reset empties the
// heap and sets k_select to 16; the RAM contents need no clearing. k_select is
// written through cfg_we/cfg_wdata; the user must do so only while idle, as the
// block does not enforce it. Zero acts as one and larger values saturate at 64.
module top_k_select_min_heap (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [tks_pkg::INDEX_BITS-1:0]        point_index,
    input  logic signed [tks_pkg::SCORE_BITS-1:0] score,
    input  logic                                  last_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tks_pkg::INDEX_BITS-1:0]        point_index_res,
    output logic [tks_pkg::RANK_W-1:0]            rank,
    output logic                                  last_result,
    input  logic                                  cfg_we,
    input  logic [tks_pkg::K_SEL_W-1:0]           cfg_wdata
);
    import tks_pkg::*;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;
    logic              out_free;
    out_load_t         out_load;

    // Heap storage: score and index of each kept entry in one word.
    tks_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (K_MAX)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer for insert, replace, end-of-batch sort and readout.
    tks_heap_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_index (point_index),
        .score       (score),
        .last_item   (last_item),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_free    (out_free),
        .out_load    (out_load)
    );

    // The output register decouples the readout from a stalling receiver.
    tks_out_stage u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .load_in         (out_load),
        .free            (out_free),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .point_index_res (point_index_res),
        .rank            (rank),
        .last_result     (last_result)
    );

endmodule

// ----- test/tks_topk_scoreboard.sv -----
// Scoreboard for the top-K selector: follows both channels and the k_select port,
// predicts the ranked results of every batch and compares them with the block's output.
// Depends on tks_pkg for widths and the heap size.
module tks_topk_scoreboard (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [tks_pkg::INDEX_BITS-1:0]        point_index,
    input  logic signed [tks_pkg::SCORE_BITS-1:0] score,
    input  logic                                  last_item,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [tks_pkg::INDEX_BITS-1:0]        point_index_res,
    input  logic [tks_pkg::RANK_W-1:0]            rank,
    input  logic                                  last_result,
    input  logic                                  cfg_we,
    input  logic [tks_pkg::K_SEL_W-1:0]           cfg_wdata,
    output int                                    errors,
    output int                                    pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tks_pkg::*;

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic [RANK_W-1:0]     pos;
        logic                  final_one;
    } pick_t;

    pick_t                        picks_q[$];
    logic signed [SCORE_BITS-1:0] kept_score[K_MAX];
    logic [INDEX_BITS-1:0]        kept_idx[K_MAX];
    int                           kept_n;
    int                           k_reg;

    // Entry a ranks above entry b: higher score, or the same score and a smaller index.
    function automatic bit ranks_above(input logic signed [SCORE_BITS-1:0] sa,
                                       input logic [INDEX_BITS-1:0] ia,
                                       input logic signed [SCORE_BITS-1:0] sb,
                                       input logic [INDEX_BITS-1:0] ib);
        return (sa > sb) || ((sa == sb) && (ia < ib));
    endfunction

    function automatic int k_applied();
        int k;
        k = k_reg;
        if (k < 1)
            k = 1;
        if (k > K_MAX)
            k = K_MAX;
        return k;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Take one candidate into the kept set: a free slot first, otherwise replace the
    // worst entry when the new score is strictly higher.
    task automatic absorb(input logic [INDEX_BITS-1:0] idx,
                          input logic signed [SCORE_BITS-1:0] sc);
        int w;
        int i;
        if (kept_n < k_applied())
        begin
            kept_score[kept_n] = sc;
            kept_idx[kept_n]   = idx;
            kept_n++;
        end
        else
        begin
            w = 0;
            for (i = 1; i < kept_n; i++)
                if (ranks_above(kept_score[w], kept_idx[w], kept_score[i], kept_idx[i]))
                    w = i;
            if (sc > kept_score[w])
            begin
                kept_score[w] = sc;
                kept_idx[w]   = idx;
            end
        end
    endtask

    // Order the kept entries best first and queue the ones that will be emitted.
    task automatic rank_batch();
        logic signed [SCORE_BITS-1:0] s[K_MAX];
        logic [INDEX_BITS-1:0]        ix[K_MAX];
        logic signed [SCORE_BITS-1:0] ts;
        logic [INDEX_BITS-1:0]        ti;
        pick_t                        p;
        int                           emit;
        int                           best;
        int                           i;
        int                           j;
        for (i = 0; i < kept_n; i++)
        begin
            s[i]  = kept_score[i];
            ix[i] = kept_idx[i];
        end
        emit = (kept_n < k_applied()) ? kept_n : k_applied();
        for (i = 0; i < emit; i++)
        begin
            best = i;
            for (j = i + 1; j < kept_n; j++)
                if (ranks_above(s[j], ix[j], s[best], ix[best]))
                    best = j;
            ts = s[i];  s[i]  = s[best];  s[best]  = ts;
            ti = ix[i]; ix[i] = ix[best]; ix[best] = ti;
            p.idx       = ix[i];
            p.pos       = RANK_W'(i);
            p.final_one = (i == emit - 1);
            picks_q.push_back(p);
        end
        kept_n = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pick_t want;
        if (!rst_n)
        begin
            kept_n  = 0;
            k_reg   = 16;
            errors  = 0;
            picks_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                k_reg = int'(cfg_wdata);
            if (in_valid && in_ready)
            begin
                absorb(point_index, score);
                if (last_item)
                    rank_batch();
            end
            if (out_valid && out_ready)
            begin
                if (picks_q.size() == 0)
                begin
                    report("result with nothing pending", longint'(point_index_res),
                           longint'(-1));
                end
                else
                begin
                    want = picks_q.pop_front();
                    if (point_index_res !== want.idx)
                        report("point_index_res", longint'(point_index_res),
                               longint'(want.idx));
                    if (rank !== want.pos)
                        report("rank", longint'(rank), longint'(want.pos));
                    if (last_result !== want.final_one)
                        report("last_result", longint'(last_result),
                               longint'(want.final_one));
                end
            end
            pending = picks_q.size();
        end
    end

endmodule

// ----- test/tb_top_k_select_min_heap.sv -----
// Testbench top for the streaming top-K selector: drives batches of scored requests,
// changes k_select between batches and gives the verdict.
// Depends on tks_pkg, the block top_k_select_min_heap and tks_topk_scoreboard.
module tb_top_k_select_min_heap;
    timeunit 1ns;
    timeprecision 1ps;
    import tks_pkg::*;

    // Watchdog bound, with ample margin over the slowest correct run, even with the
    // full 64-entry heapsort and long receiver stalls.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles left to the block after the last result before k_select is touched or
    // the run ends.
    localparam int SETTLE_CYCLES = 40;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [INDEX_BITS-1:0]        point_index = '0;
    logic signed [SCORE_BITS-1:0] score = '0;
    logic                         last_item = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [INDEX_BITS-1:0]        point_index_res;
    logic [RANK_W-1:0]            rank;
    logic                         last_result;
    logic                         cfg_we = 1'b0;
    logic [K_SEL_W-1:0]           cfg_wdata = '0;

    int errors;
    int pending;
    int cycles = 0;
    // Percentage of cycles in which the sender and the receiver hold back.
    int send_idle = 0;
    int recv_idle = 0;

    always #5 clk = ~clk;

    top_k_select_min_heap uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .point_index     (point_index),
        .score           (score),
        .last_item       (last_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .point_index_res (point_index_res),
        .rank            (rank),
        .last_result     (last_result),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    tks_topk_scoreboard scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .point_index     (point_index),
        .score           (score),
        .last_item       (last_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .point_index_res (point_index_res),
        .rank            (rank),
        .last_result     (last_result),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .errors          (errors),
        .pending         (pending)
    );

    // The receiver decides afresh every cycle whether it takes a result.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one request and hold it until the block accepts it. Called just after a
    // rising edge; returns just after the accepting edge with valid still high, so a
    // following request can go out back to back.
    task automatic push_request(input logic [INDEX_BITS-1:0] idx,
                                input logic signed [SCORE_BITS-1:0] sc,
                                input logic lst);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        point_index <= idx;
        score       <= sc;
        last_item   <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Wait until every predicted result has been taken, then give the block time to
    // fall idle. Pending is read at the falling edge, after all updates of the rising one.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // k_select is only changed while the block sits idle.
    task automatic set_k(input logic [K_SEL_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Scores mix full-range values with a narrow band around zero, where equal scores
    // and the index tie-break come up often, and the two extremes.
    function automatic logic signed [SCORE_BITS-1:0] rand_score();
        case ($urandom_range(3))
            0:       return SCORE_BITS'($urandom_range(8)) - SCORE_BITS'(4);
            1:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [INDEX_BITS-1:0] rand_idx();
        return $urandom_range(1) ? INDEX_BITS'($urandom) : INDEX_BITS'($urandom_range(15));
    endfunction

    // Zero and values above the heap size exercise the clamping of k_select.
    function automatic logic [K_SEL_W-1:0] pick_k();
        case ($urandom_range(5))
            0:       return K_SEL_W'(0);
            1:       return K_SEL_W'(1);
            2:       return K_SEL_W'(K_MAX);
            3:       return K_SEL_W'($urandom_range(65, 127));
            default: return K_SEL_W'($urandom_range(2, 12));
        endcase
    endfunction

    initial
    begin
        int phase;
        int batch;
        int len;
        int n_phase;
        int i;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, k_select at its reset value of 16. A lone request is a whole
        // batch: fewer items than k_select, yet one result.
        push_request(20'h00000, 32'sh8000_0000, 1'b1);
        // Extremes of both fields; the two top scores tie and the smaller index wins.
        push_request(20'hFFFFF, 32'sh7FFF_FFFF, 1'b0);
        push_request(20'h00005, 32'sh7FFF_FFFF, 1'b0);
        push_request(20'h00003, -32'sd1,        1'b0);
        push_request(20'h00007, 32'sd0,         1'b0);
        push_request(20'hAAAAA, 32'sh8000_0000, 1'b0);
        push_request(20'h55555, 32'sd1,         1'b1);

        // Zero acts as one: a score equal to the kept minimum is dropped even with a
        // smaller index, a lower one is dropped, a higher one replaces it.
        set_k(K_SEL_W'(0));
        push_request(20'd10, 32'sd100, 1'b0);
        push_request(20'd5,  32'sd100, 1'b0);
        push_request(20'd20, 32'sd50,  1'b0);
        push_request(20'd30, 32'sd200, 1'b1);

        // Full heap of two, third request ties on score and must not get in.
        set_k(K_SEL_W'(2));
        push_request(20'd1, 32'sd5, 1'b0);
        push_request(20'd2, 32'sd5, 1'b0);
        push_request(20'd0, 32'sd5, 1'b1);

        // The largest register value saturates to the heap size.
        set_k(K_SEL_W'(127));
        for (i = 0; i < 5; i++)
            push_request(rand_idx(), rand_score(), i == 4);

        // Random part in three handshake regimes. Every batch ends on a flagged request;
        // k_select changes before some batches, and otherwise the next batch may start
        // while the final result of the previous one still waits.
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 28 : (phase == 1) ? 55 : 0;
            recv_idle = (phase == 0) ? 55 : (phase == 1) ? 28 : 0;
            n_phase = 0;
            batch = 0;
            while (n_phase < 45)
            begin
                if (phase == 0 && batch == 0)
                begin
                    // Overfill the largest heap so replacement runs at full depth.
                    set_k(K_SEL_W'(K_MAX));
                    len = K_MAX + 6;
                end
                else
                begin
                    if (batch == 0 || $urandom_range(2) == 0)
                        set_k(pick_k());
                    len = $urandom_range(1, 12);
                end
                for (i = 0; i < len; i++)
                    push_request(rand_idx(), rand_score(), i == len - 1);
                n_phase += len;
                batch++;
            end
        end

        settle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
